>>> rtl/bfiq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfiq_pkg
// Shared types and constants of the bloom filter insert/query unit.
// ---------------------------------------------------------------------------
package bfiq_pkg;

    localparam logic [31:0] FNV_MULT   = 32'd16777619;
    localparam logic [31:0] FNV_SEED   = 32'd2166136261;
    localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2      = 32'h1b873593;
    localparam logic [31:0] MM_N       = 32'he6546b64;
    localparam logic [31:0] MM_F1      = 32'h85ebca6b;
    localparam logic [31:0] MM_F2      = 32'hc2b2ae35;
    localparam logic [31:0] MM_FIVE    = 32'd5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic REG_FILTER_SIZE = 1'b0;
    localparam logic REG_HASH_COUNT  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F1,
        ST_K1,
        ST_K2,
        ST_MX,
        ST_MW,
        ST_FM1,
        ST_FM2,
        ST_FM3,
        ST_WF,
        ST_WM,
        ST_PROBE,
        ST_CHK,
        ST_OUT
    } t_state;

    // Bit store access controls: write, read and write data
    typedef struct packed {
        logic wr;
        logic rd;
        logic wdata;
    } t_mem_ctl;

endpackage

>>> rtl/bfiq_mod.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfiq_mod
// Iterative remainder unit: 32-bit dividend, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bfiq_mod #(
    parameter int SW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_rem
);

    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [31:0]   r_dvd;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_div;
    logic          r_done;
    logic [SW:0]   w_trial;
    logic [SW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[31]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = SW'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/bfiq_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfiq_store
// Filter bit memory with registered read and a clearing sweep after reset.
// ---------------------------------------------------------------------------
module bfiq_store
    import bfiq_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    output logic          o_rdata,
    output logic          o_ready
);

    logic          r_mem [DEPTH];
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_ctl.wr) begin
            r_mem[i_addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

>>> rtl/bloom_filter_insert_query_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bloom_filter_insert_query_unit
// Bloom filter over byte-stream keys, FNV-1a and Murmur-style double hashing.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one key byte per transfer. tdata[7:0] byte, tdata[8]
//   has_byte, tuser operation (0 insert, 1 query), tlast ends the key.
//   Master stream: one result per key. tdata[0] found, tuser operation.
//   Config: i_cfg_we with i_cfg_index 0 filter size, 1 hash count; write
//   only while idle.
// Sequence:
//   A byte goes through accept, four shared 32x32 multiplies and one add.
//   Key end adds the fmix steps, two remainder runs, one probe per hash
//   and a check step, and the output load. The probe count is the hash
//   count, at least 2 and at most MAX_HASHES.
// Reset:
//   After reset the bit store is swept clear; during the sweep no transfer
//   is accepted, while config writes are taken as ever.
// Stall:
//   The result sits in an output register; the unit holds its key-end
//   step until that register is free.
// ---------------------------------------------------------------------------
module bloom_filter_insert_query_unit
    import bfiq_pkg::*;
#(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] has_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] found
    output logic [0:0]  m_axis_tuser,   // [0] done_operation
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [16:0] i_cfg_wdata
);

    localparam int AW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
    localparam int SW = $clog2(FILTER_BITS + 1);
    localparam int HW = $clog2(MAX_HASHES + 1);

    t_state        r_state, n_state;
    logic [16:0]   r_cfg_size;
    logic [4:0]    r_cfg_hc;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_op;
    logic [31:0]   r_fnv;
    logic [31:0]   r_mur;
    logic [31:0]   r_prod;
    logic [AW-1:0] r_m;
    logic [AW-1:0] r_q;
    logic [HW-1:0] r_i;
    logic          r_all;
    logic          r_chk;
    logic          r_ovalid;
    logic          r_found;
    logic          r_oop;

    logic [SW-1:0] w_size;
    logic [HW-1:0] w_nprb;
    logic [31:0]   w_ma, w_mb, w_mx, w_fx;
    logic [31:0]   w_mul;
    logic [AW:0]   w_sum;
    logic [AW-1:0] w_qnext;
    logic [AW-1:0] w_addr;
    t_mem_ctl      w_ctl;
    logic          w_rdata;
    logic          w_mem_ready;
    logic          w_mod_start;
    logic [31:0]   w_mod_dvd;
    logic          w_mod_done;
    logic [SW-1:0] w_mod_rem;
    logic          w_accept;
    logic          w_out_free;

    // Effective filter size and probe count
    always_comb begin
        if (r_cfg_size == 17'd0) begin
            w_size = SW'(1);
        end else if (32'(r_cfg_size) > 32'(FILTER_BITS)) begin
            w_size = SW'(FILTER_BITS);
        end else begin
            w_size = SW'(r_cfg_size);
        end
        if (r_cfg_hc < 5'd2) begin
            w_nprb = HW'(2);
        end else if (32'(r_cfg_hc) > 32'(MAX_HASHES)) begin
            w_nprb = HW'(MAX_HASHES);
        end else begin
            w_nprb = HW'(r_cfg_hc);
        end
    end

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_mx       = {r_prod[16:0], r_prod[31:17]};
    assign w_fx       = r_mur ^ r_prod;
    assign w_mul      = w_ma * w_mb;

    // Next probe position, reduced by one compare and subtract
    always_comb begin
        w_sum = {1'b0, r_q} + {1'b0, r_m};
        if (w_sum >= (AW+1)'(w_size)) begin
            w_qnext = AW'(w_sum - (AW+1)'(w_size));
        end else begin
            w_qnext = w_sum[AW-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (w_mem_ready) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tdata[8]) begin
                        n_state = ST_F1;
                    end else if (s_axis_tlast) begin
                        n_state = ST_FM1;
                    end
                end
            end
            ST_F1:  n_state = ST_K1;
            ST_K1:  n_state = ST_K2;
            ST_K2:  n_state = ST_MX;
            ST_MX:  n_state = ST_MW;
            ST_MW:  n_state = r_last ? ST_FM1 : ST_IDLE;
            ST_FM1: n_state = ST_FM2;
            ST_FM2: n_state = ST_FM3;
            ST_FM3: n_state = ST_WF;
            ST_WF:  if (w_mod_done) n_state = ST_WM;
            ST_WM:  if (w_mod_done) n_state = ST_PROBE;
            ST_PROBE: if (r_i == w_nprb) n_state = ST_CHK;
            ST_CHK: n_state = ST_OUT;
            ST_OUT: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operands, memory and divider
    always_comb begin
        w_ma        = r_prod;
        w_mb        = MM_F2;
        w_ctl       = '0;
        w_mod_start = 1'b0;
        w_mod_dvd   = r_fnv;
        s_axis_tready = (r_state == ST_IDLE);
        if (r_i == HW'(1)) begin
            w_addr = r_q;
        end else if (r_i == HW'(2)) begin
            w_addr = r_m;
        end else begin
            w_addr = w_qnext;
        end
        case (r_state)
            ST_F1: begin
                w_ma = r_fnv ^ {24'd0, r_byte};
                w_mb = FNV_MULT;
            end
            ST_K1: begin
                w_ma = {24'd0, r_byte};
                w_mb = MM_C1;
            end
            ST_K2: begin
                w_ma = w_mx;
                w_mb = MM_C2;
            end
            ST_MX: begin
                w_ma = {w_fx[18:0], w_fx[31:19]};
                w_mb = MM_FIVE;
            end
            ST_FM1: begin
                w_ma = r_mur;
                w_mb = MM_F1;
            end
            ST_FM2: begin
                w_ma = r_prod ^ (r_prod >> 13);
                w_mb = MM_F2;
            end
            ST_FM3: begin
                w_mod_start = 1'b1;
                w_mod_dvd   = r_fnv;
            end
            ST_WF: begin
                w_mod_start = w_mod_done;
                w_mod_dvd   = r_mur;
            end
            ST_PROBE: begin
                w_ctl.wr    = (r_op == OP_INSERT);
                w_ctl.rd    = (r_op == OP_QUERY);
                w_ctl.wdata = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cfg_size <= 17'd65536;
            r_cfg_hc   <= 5'd2;
            r_ovalid   <= 1'b0;
            r_chk      <= 1'b0;
            r_fnv      <= FNV_SEED;
            r_mur      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FILTER_SIZE: r_cfg_size <= i_cfg_wdata;
                    REG_HASH_COUNT:  r_cfg_hc   <= i_cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            // Drop the result on transfer unless a new one loads this cycle
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            r_chk <= (r_state == ST_PROBE) && (r_op == OP_QUERY);
            if (r_chk && !w_rdata) begin
                r_all <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_byte <= s_axis_tdata[7:0];
                        r_last <= s_axis_tlast;
                        r_op   <= s_axis_tuser[0];
                    end
                end
                ST_F1:  r_prod <= w_mul;
                ST_K1: begin
                    r_fnv  <= r_prod;
                    r_prod <= w_mul;
                end
                ST_K2:  r_prod <= w_mul;
                ST_MX:  r_prod <= w_mul;
                ST_MW:  r_mur  <= r_prod + MM_N;
                ST_FM1: r_prod <= w_mul;
                ST_FM2: r_prod <= w_mul;
                ST_FM3: r_mur  <= r_prod ^ (r_prod >> 16);
                ST_WF: begin
                    if (w_mod_done) begin
                        r_q <= w_mod_rem[AW-1:0];
                    end
                end
                ST_WM: begin
                    if (w_mod_done) begin
                        r_m   <= w_mod_rem[AW-1:0];
                        r_i   <= HW'(1);
                        r_all <= 1'b1;
                    end
                end
                ST_PROBE: begin
                    r_q <= w_qnext;
                    r_i <= r_i + 1'b1;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_found  <= (r_op == OP_QUERY) ? r_all : 1'b1;
                        r_oop    <= r_op;
                        r_fnv    <= FNV_SEED;
                        r_mur    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    bfiq_mod #(
        .SW (SW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_size),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    bfiq_store #(
        .DEPTH (FILTER_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (w_addr),
        .o_rdata (w_rdata),
        .o_ready (w_mem_ready)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_found};
    assign m_axis_tuser  = r_oop;

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing sweep");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> ((AW+1)'(w_addr) < (AW+1)'(w_size)))
        else $error("probe address beyond filter size");

    a_probe_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_i <= w_nprb))
        else $error("probe counter overran");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result loaded outside key end");

endmodule
